// ===== rtl/bais_pkg.sv =====
// ----------------------------------------------------------------------------
// bais_pkg
// Shared types and constants for the bounded array insert/erase/sort unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bais_pkg;

    // fixed field widths of the request, response and register words
    localparam int unsigned REQ_TYPE_W = 2;
    localparam int unsigned POS_W      = 7;
    localparam int unsigned RUN_W      = 7;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned TOTAL_W    = 7;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 7;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_ERASE  = 2'd1,
        REQ_SORT   = 2'd2,
        REQ_READ   = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_POS = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_RUN     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'd0,
        CFG_SORT_DESC = 1'd1
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_DOWN,
        CELL_SORT,
        CELL_ROTATE
    } cell_op_t;

    // broadcast control word seen by every cell of the chain
    typedef struct packed {
        cell_op_t op;
        logic     phase;
        logic     descending;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bais_if.sv =====
// ----------------------------------------------------------------------------
// bais_req_if / bais_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface bais_req_if;
    import bais_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [POS_W-1:0]      position;
    logic [RUN_W-1:0]      run_length;
    logic [WORD_W-1:0]     value;

    modport source (output valid, output req_type, output position, output run_length,
                    output value, input ready);
    modport sink   (input valid, input req_type, input position, input run_length,
                    input value, output ready);
endinterface

interface bais_rsp_if;
    import bais_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_value;
    logic [TOTAL_W-1:0]  element_total;

    modport source (output valid, output status, output read_value, output element_total,
                    input ready);
    modport sink   (input valid, input status, input read_value, input element_total,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/bounded_array_insert_erase_sort_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_array_insert_erase_sort_unit
// Bounded ordered array held in a chain of neighbor-linked cells.
// ----------------------------------------------------------------------------
// operation: insert shifts the entries from the position up one cell, erase
//   shifts them down by the run length, sort of n >= 2 elements runs
//   odd-even transposition passes over the cell chain, read rotates the
//   chain one full turn
// throughput: one request at a time; the next is taken once the result is
//   in the output register, which then waits for the sink on its own
// reset: asynchronous active low; count, capacity and sort order reset,
//   cell contents are left as they are and never read before being written
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_insert_erase_sort_unit
    import bais_pkg::*;
#(
    parameter int unsigned DEPTH       = 64,
    parameter int unsigned VALUE_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    bais_req_if.sink                   req,
    bais_rsp_if.source                 rsp
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned WW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // configuration
    logic [CFG_DATA_W-1:0] cap_reg;
    logic                  desc_reg;

    // control state
    ctrl_state_t           state_reg, state_next;
    cell_op_t              op_reg, op_next;
    logic [CW-1:0]         step_reg, step_next;
    logic [CW-1:0]         limit_reg, limit_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    status_t               status_reg, status_next;
    logic [VALUE_WIDTH-1:0] rd_reg, rd_next;
    logic [VALUE_WIDTH-1:0] ins_reg, ins_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [WORD_W-1:0]     out_rd_reg, out_rd_next;
    logic [TOTAL_W-1:0]    out_total_reg, out_total_next;

    cell_ctrl_t            cell_ctrl;
    logic [VALUE_WIDTH-1:0] cell_word [DEPTH];
    logic                  cell_swap [DEPTH];

    logic [WW-1:0]         cap_w, cnt_w, pos_w, run_w, end_w;
    logic [63:0]           ins_wide, rd_wide;
    logic                  accept;

    assign accept = (state_reg == ST_IDLE) && req.valid;
    assign req.ready = (state_reg == ST_IDLE);

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.read_value    = out_rd_reg;
    assign rsp.element_total = out_total_reg;

    assign ins_wide = {32'd0, req.value};
    assign rd_wide  = 64'(rd_reg);

    assign cell_ctrl.op         = (state_reg == ST_RUN) ? op_reg : CELL_HOLD;
    assign cell_ctrl.phase      = step_reg[0];
    assign cell_ctrl.descending = desc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAPACITY_RESET;
            desc_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CAPACITY:  cap_reg  <= cfg_wdata;
                CFG_SORT_DESC: desc_reg <= cfg_wdata[0];
                default:       cap_reg  <= cap_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        step_next       = step_reg;
        limit_next      = limit_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        status_next     = status_reg;
        rd_next         = rd_reg;
        ins_next        = ins_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_rd_next     = out_rd_reg;
        out_total_next  = out_total_reg;

        cap_w = (WW'(cap_reg) > DEPTH_W) ? DEPTH_W : WW'(cap_reg);
        cnt_w = WW'(cnt_reg);
        pos_w = WW'(req.position);
        run_w = WW'(req.run_length);
        end_w = pos_w + run_w;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STATUS_OK;
                    rd_next     = '0;
                    step_next   = '0;
                    pos_next    = CW'(req.position);
                    ins_next    = ins_wide[VALUE_WIDTH-1:0];
                    state_next  = ST_DONE;
                    case (req_type_t'(req.req_type))
                        REQ_INSERT:
                        begin
                            // full is checked ahead of a bad position
                            if (cnt_w + 1'b1 > cap_w)
                                status_next = STATUS_FULL;
                            else if (pos_w > cnt_w)
                                status_next = STATUS_BAD_POS;
                            else
                            begin
                                op_next    = CELL_INSERT;
                                limit_next = CW'(1);
                                cnt_next   = cnt_reg + 1'b1;
                                state_next = ST_RUN;
                            end
                        end
                        REQ_ERASE:
                        begin
                            if (end_w > cnt_w)
                                status_next = STATUS_RUN;
                            else if (run_w != '0)
                            begin
                                op_next    = CELL_SHIFT_DOWN;
                                limit_next = CW'(req.run_length);
                                cnt_next   = cnt_reg - CW'(req.run_length);
                                state_next = ST_RUN;
                            end
                        end
                        REQ_SORT:
                        begin
                            // n transposition phases sort n elements
                            if (cnt_w > WW'(1))
                            begin
                                op_next    = CELL_SORT;
                                limit_next = cnt_reg;
                                state_next = ST_RUN;
                            end
                        end
                        REQ_READ:
                        begin
                            if (pos_w < cnt_w)
                            begin
                                op_next    = CELL_ROTATE;
                                limit_next = DEPTH_C;
                                state_next = ST_RUN;
                            end
                            else
                                status_next = STATUS_BAD_POS;
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // after k rotations cell 0 holds the original entry k
                if ((op_reg == CELL_ROTATE) && (step_reg == pos_reg))
                    rd_next = cell_word[0];
                step_next = step_reg + 1'b1;
                if (step_reg == CW'(limit_reg - 1'b1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_rd_next     = rd_wide[WORD_W-1:0];
                    out_total_next  = TOTAL_W'(cnt_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= CELL_HOLD;
            step_reg      <= '0;
            limit_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            limit_reg     <= limit_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        status_reg     <= status_next;
        rd_reg         <= rd_next;
        ins_reg        <= ins_next;
        out_status_reg <= out_status_next;
        out_rd_reg     <= out_rd_next;
        out_total_reg  <= out_total_next;
    end

    // cell chain; the last cell's right neighbor is cell 0 so the chain can rotate
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_w;
        logic                   swap_l;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
            assign swap_l = 1'b0;
        end
        else
        begin : g_rest
            assign left_w = cell_word[i-1];
            assign swap_l = cell_swap[i-1];
        end

        bais_cell #(
            .INDEX       (i),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CW          (CW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .pos        (pos_reg),
            .count      (cnt_reg),
            .ins_word   (ins_reg),
            .left_word  (left_w),
            .right_word (cell_word[(i + 1) % DEPTH]),
            .swap_left  (swap_l),
            .word       (cell_word[i]),
            .swap_right (cell_swap[i])
        );
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("element count above depth");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg < limit_reg))
        else $error("step counter ran past its limit");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    a_cells_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> (cell_ctrl.op == CELL_HOLD))
        else $error("cell chain moved outside of a run");

    a_done_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not loaded into the output register");

endmodule

`default_nettype wire

// ===== rtl/bais_cell.sv =====
// ----------------------------------------------------------------------------
// bais_cell
// One storage cell of the element chain: holds a word and trades it with
// its neighbors for insert shifts, erase shifts, rotation and sort swaps.
// ----------------------------------------------------------------------------
`default_nettype none

module bais_cell
    import bais_pkg::*;
#(
    parameter int unsigned INDEX       = 0,
    parameter int unsigned VALUE_WIDTH = 32,
    parameter int unsigned CW          = 7
)
(
    input  wire logic                   clk,
    input  wire cell_ctrl_t             ctrl,
    input  wire logic [CW-1:0]          pos,
    input  wire logic [CW-1:0]          count,
    input  wire logic [VALUE_WIDTH-1:0] ins_word,
    input  wire logic [VALUE_WIDTH-1:0] left_word,
    input  wire logic [VALUE_WIDTH-1:0] right_word,
    input  wire logic                   swap_left,
    output logic      [VALUE_WIDTH-1:0] word,
    output logic                        swap_right
);

    localparam logic [CW-1:0] MY_IDX   = CW'(INDEX);
    localparam logic [CW-1:0] NEXT_IDX = CW'(INDEX + 1);
    localparam logic          PARITY   = 1'(INDEX % 2);

    logic [VALUE_WIDTH-1:0] word_reg;
    logic [VALUE_WIDTH-1:0] word_next;
    logic                   out_of_order;

    assign word = word_reg;

    always_comb
    begin
        out_of_order = ctrl.descending ? (word_reg < right_word) : (word_reg > right_word);
        // swap when this cell is the lower half of an active pair in the current phase and the pair is out of order
        swap_right   = (ctrl.op == CELL_SORT) && (ctrl.phase == PARITY) &&
                       (NEXT_IDX < count) && out_of_order;
    end

    always_comb
    begin
        word_next = word_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (MY_IDX > pos)
                    word_next = left_word;
                else if (MY_IDX == pos)
                    word_next = ins_word;
            end
            CELL_SHIFT_DOWN:
            begin
                if (MY_IDX >= pos)
                    word_next = right_word;
            end
            CELL_ROTATE:
            begin
                word_next = right_word;
            end
            CELL_SORT:
            begin
                if (swap_right)
                    word_next = right_word;
                else if (swap_left)
                    word_next = left_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

`default_nettype wire
